/* rtl/lpht_pkg.sv */
// Shared types and constants for the linear-probing hash table.
package lpht_pkg;

  localparam int HASH_W   = 32;
  localparam int FIELD_W  = 32;
  localparam int CAP_W    = 9;
  localparam int LOAD_W   = 7;
  localparam int CNT_W    = 9;
  localparam int STAT_W   = 3;
  localparam int FUNC_W   = 2;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 1;

  localparam int CAP_LIMIT = (1 << CAP_W) - 1;

  localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_UPDATED   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;
  localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD     = 1'd1;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd256;
  localparam logic [LOAD_W-1:0] LOAD_RESET = 7'd75;
  localparam logic [LOAD_W-1:0] PCT_MAX    = 7'd100;

  localparam int PROD_W      = 16;
  localparam int RECIP_W     = 17;
  localparam int Q_W         = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] key;
    logic [HASH_W-1:0]  key_hash;
    logic [FIELD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] value_out;
    logic [CNT_W-1:0]   entry_count;
  } out_item_t;

endpackage

/* rtl/lpht_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lpht_mod.sv */
// Bit-serial remainder unit that reduces the key hash modulo the capacity.
module lpht_mod import lpht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [CAP_W-1:0]  divisor,
  output logic              done,
  output logic [CAP_W-1:0]  remainder
);

  localparam int STEP_W = $clog2(HASH_W);

  logic [HASH_W-1:0] dividend_r;
  logic [CAP_W-1:0]  div_r;
  logic [CAP_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [CAP_W:0]    trial;

  always_comb begin
    trial = {rem_r, dividend_r[HASH_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CAP_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = CAP_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(HASH_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend_r <= dividend;
      div_r      <= divisor;
      rem_r      <= '0;
    end else if (run_r) begin
      dividend_r <= {dividend_r[HASH_W-2:0], 1'b0};
      rem_r      <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* rtl/lpht_limit.sv */
// Pipelined computation of the fill limit, floor(load percentage times capacity / 100).
module lpht_limit import lpht_pkg::*; (
  input  logic              clk,
  input  logic [CAP_W-1:0]  cap,
  input  logic [LOAD_W-1:0] load,
  output logic [CAP_W-1:0]  limit
);

  logic [LOAD_W-1:0] load_c;
  logic [PROD_W-1:0] prod_r;
  logic [Q_W-1:0]    q_r;

  assign load_c = (load > PCT_MAX) ? PCT_MAX : load;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(load_c) * PROD_W'(cap);
    q_r    <= Q_W'(prod_r) * Q_W'(RECIP_100);
  end

  assign limit = q_r[RECIP_SHIFT +: CAP_W];

endmodule

/* rtl/linear_probe_hash_table.sv */
// Top level of the open-addressing key/value table with linear probing.
//
// Each transfer on the input side is a put, get or remove; each produces exactly one
// result, shown for one cycle on out_strobe, which the receiver cannot stall. An item
// first reduces its hash modulo the capacity in the bit-serial remainder unit, then acts
// on the remainder, then passes through a memory read state and probes one slot at a
// time before the result is registered; a put refused at the load limit, or an unused
// function code, skips the read and the probes. The key memory's single read port sets
// the probe rate of one slot per cycle. busy falls in the cycle the result is shown, so
// the next item can be taken then. After reset a clearing pass empties the table, with
// busy high; configuration writes are taken throughout.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int SLOTS      = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CAP_MAX = (SLOTS < CAP_LIMIT) ? SLOTS : CAP_LIMIT;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_READ  = 5'b01000,
    S_PROBE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CAP_W-1:0]  cap_r;
  logic [LOAD_W-1:0] load_r;
  logic [CAP_W-1:0]  cap_eff;
  logic [CAP_W-1:0]  limit;

  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [CAP_W-1:0]  pos_r, pos_nxt;
  logic [CAP_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              strobe_r, strobe_nxt;
  out_item_t         out_r, out_nxt;

  logic [FUNC_W-1:0]     func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  logic                 accept;
  logic                 mod_done;
  logic [CAP_W-1:0]     mod_rem;

  logic                 key_we, val_we;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [KEY_BITS:0]    key_wdata, key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;

  logic                 slot_valid, hit, last;
  logic [CAP_W:0]       pos_inc, n_inc;
  logic [CAP_W-1:0]     next_pos;
  logic [STAT_W-1:0]    fin_status;
  logic [FIELD_W-1:0]   fin_value;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cap_r) > CAP_MAX) begin
      cap_eff = CAP_W'(CAP_MAX);
    end else begin
      cap_eff = cap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      load_r <= LOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: cap_r  <= cfg_data;
        CFG_LOAD:     load_r <= cfg_data[LOAD_W-1:0];
        default:      ;
      endcase
    end
  end

  lpht_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .dividend  (in_item.key_hash),
    .divisor   (cap_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  lpht_limit u_limit (
    .clk   (clk),
    .cap   (cap_eff),
    .load  (load_r),
    .limit (limit)
  );

  lpht_ram #(.WIDTH(KEY_BITS + 1), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_addr),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  assign slot_valid = key_rdata[KEY_BITS];
  assign hit        = slot_valid && (key_rdata[KEY_BITS-1:0] == key_r);
  assign pos_inc    = {1'b0, pos_r} + 1'b1;
  assign next_pos   = (pos_inc == {1'b0, cap_eff}) ? '0 : pos_inc[CAP_W-1:0];
  assign n_inc      = {1'b0, n_r} + 1'b1;
  assign last       = (n_inc == {1'b0, cap_eff});

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    pos_nxt    = pos_r;
    n_nxt      = n_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    fin_status = STAT_NOT_FOUND;
    fin_value  = '0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    key_wdata  = {1'b1, key_r};
    wr_addr    = IDX_W'(pos_r);
    rd_addr    = IDX_W'(pos_r);

    case (state_r)
      S_CLEAR: begin
        key_we    = 1'b1;
        key_wdata = '0;
        wr_addr   = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          if ((func_r == FUNC_PUT) && (count_r >= limit)) begin
            fin_status = STAT_FULL;
            strobe_nxt = 1'b1;
          end else if (!(func_r inside {FUNC_PUT, FUNC_GET, FUNC_REMOVE})) begin
            fin_status = STAT_NOT_FOUND;
            strobe_nxt = 1'b1;
          end else begin
            pos_nxt   = mod_rem;
            n_nxt     = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        rd_addr = IDX_W'(next_pos);
        if (!slot_valid) begin
          strobe_nxt = 1'b1;
          if (func_r == FUNC_PUT) begin
            key_we     = 1'b1;
            val_we     = 1'b1;
            count_nxt  = count_r + 1'b1;
            fin_status = STAT_INSERTED;
          end
        end else if (hit) begin
          strobe_nxt = 1'b1;
          case (func_r)
            FUNC_PUT: begin
              val_we     = 1'b1;
              fin_status = STAT_UPDATED;
            end
            FUNC_GET: begin
              fin_status = STAT_FOUND;
              fin_value  = FIELD_W'(val_rdata);
            end
            FUNC_REMOVE: begin
              key_we     = 1'b1;
              key_wdata  = {1'b0, key_r};
              fin_status = STAT_REMOVED;
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
            end
            default: fin_status = STAT_NOT_FOUND;
          endcase
        end else if (last) begin
          strobe_nxt = 1'b1;
          fin_status = (func_r == FUNC_PUT) ? STAT_FULL : STAT_NOT_FOUND;
        end else begin
          pos_nxt = next_pos;
          n_nxt   = n_inc[CAP_W-1:0];
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (strobe_nxt) begin
      state_nxt = S_IDLE;
      out_nxt   = '{status: fin_status, value_out: fin_value, entry_count: count_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    n_r   <= n_nxt;
    out_r <= out_nxt;
    if (accept) begin
      func_r <= in_item.func;
      key_r  <= KEY_BITS'(in_item.key);
      val_r  <= VALUE_BITS'(in_item.value);
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

/* rtl/lpht_checker.sv */
// Port-level checks on the hash table's transfers, bound to the top level.
module lpht_checker import lpht_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input in_item_t             in_item,
  input logic                 out_strobe,
  input out_item_t            out_item,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transfer");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.status <= STAT_REMOVED))
    else $error("result carries an undefined status");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status != STAT_FOUND)) |-> (out_item.value_out == '0))
    else $error("value returned on a result that found nothing");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

/* tb/tb_linear_probe_hash_table.sv */
// Self-checking testbench for the linear-probing key/value table, with its own shadow table.
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int SLOTS       = 256;
  localparam int KEY_POOL    = 24;
  localparam int QUIET_LIMIT = 5000;
  localparam int END_WAIT    = 300;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY;
  logic [CFG_W-1:0]     cfg_data = '0;

  linear_probe_hash_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the table and its registers.
  logic [FIELD_W-1:0] shadow_key [SLOTS];
  logic [FIELD_W-1:0] shadow_val [SLOTS];
  bit                 shadow_used [SLOTS];
  int unsigned        shadow_count = 0;
  logic [CAP_W-1:0]   shadow_cap = CAP_RESET;
  logic [LOAD_W-1:0]  shadow_load = LOAD_RESET;

  in_item_t  queued_ops [$];
  out_item_t awaited_results [$];

  logic [FIELD_W-1:0] pool_key [KEY_POOL];
  logic [HASH_W-1:0]  pool_hash [KEY_POOL];

  int sender_idle_pct = 30;
  int ops_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_run = 0;
  int quiet_cycles = 0;
  int status_tally [8];

  function automatic out_item_t apply_to_shadow(in_item_t op);
    out_item_t   r;
    int unsigned cap;
    int unsigned lp;
    int unsigned limit;
    int unsigned pos;
    int unsigned n;
    bit          do_probe;
    bit          hit;
    bit          hole;
    cap = (shadow_cap == 0) ? 1 : ((shadow_cap > SLOTS) ? SLOTS : shadow_cap);
    lp = (shadow_load > PCT_MAX) ? PCT_MAX : shadow_load;
    limit = (lp * cap) / 100;
    do_probe = (op.func == FUNC_GET) || (op.func == FUNC_REMOVE) ||
               ((op.func == FUNC_PUT) && (shadow_count < limit));
    hit = 1'b0;
    hole = 1'b0;
    pos = 0;
    if (do_probe) begin
      pos = op.key_hash % cap;
      for (n = 0; n < cap && !hit && !hole; n++) begin
        if (!shadow_used[pos]) begin
          hole = 1'b1;
        end else if (shadow_key[pos] == op.key) begin
          hit = 1'b1;
        end else begin
          pos = (pos + 1 == cap) ? 0 : pos + 1;
        end
      end
    end
    r.status = STAT_NOT_FOUND;
    r.value_out = '0;
    case (op.func)
      FUNC_PUT: begin
        if (!do_probe) begin
          r.status = STAT_FULL;
        end else if (hit) begin
          shadow_val[pos] = op.value;
          r.status = STAT_UPDATED;
        end else if (hole) begin
          shadow_key[pos] = op.key;
          shadow_val[pos] = op.value;
          shadow_used[pos] = 1'b1;
          shadow_count++;
          r.status = STAT_INSERTED;
        end else begin
          r.status = STAT_FULL;
        end
      end
      FUNC_GET: begin
        if (hit) begin
          r.status = STAT_FOUND;
          r.value_out = shadow_val[pos];
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          shadow_used[pos] = 1'b0;
          if (shadow_count > 0) shadow_count--;
          r.status = STAT_REMOVED;
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic in_item_t make_op(logic [FUNC_W-1:0] func, logic [FIELD_W-1:0] key,
                                       logic [HASH_W-1:0] key_hash,
                                       logic [FIELD_W-1:0] value);
    in_item_t op;
    op.func = func;
    op.key = key;
    op.key_hash = key_hash;
    op.value = value;
    return op;
  endfunction

  function automatic in_item_t random_op();
    in_item_t    op;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(99);
    op.func = (pick < 45) ? FUNC_PUT : (pick < 75) ? FUNC_GET :
              (pick < 95) ? FUNC_REMOVE : FUNC_UNUSED;
    sel = $urandom_range(KEY_POOL - 1);
    if ($urandom_range(99) < 88) begin
      op.key = pool_key[sel];
      op.key_hash = ($urandom_range(99) < 92) ? pool_hash[sel] : $urandom();
    end else begin
      op.key = $urandom();
      op.key_hash = $urandom();
    end
    op.value = $urandom();
    return op;
  endfunction

  task automatic log_mismatch(string what);
    mismatches++;
    $display("MISMATCH at result %0d: %s", results_seen, what);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) shadow_cap = data;
    else shadow_load = data[LOAD_W-1:0];
  endtask

  // Waits until no transfer is pending or in flight, sampled away from the rising edge.
  task automatic settle();
    do @(negedge clk);
    while (queued_ops.size() != 0 || start || busy || awaited_results.size() != 0);
  endtask

  task automatic set_table(logic [CFG_W-1:0] cap, logic [CFG_W-1:0] load);
    settle();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_LOAD, load);
    settings_run++;
  endtask

  // Removes every stored entry by starting each probe on the entry's own slot.
  task automatic drain_table();
    settle();
    write_reg(CFG_CAPACITY, CAP_RESET);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_used[i]) queued_ops.push_back(make_op(FUNC_REMOVE, shadow_key[i], i, $urandom()));
    end
    settle();
  endtask

  task automatic run_phase(logic [CFG_W-1:0] cap, logic [CFG_W-1:0] load, int count, int idle);
    set_table(cap, load);
    sender_idle_pct = idle;
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_key[i] = $urandom();
      pool_hash[i] = $urandom();
      if (i % 2 == 0) pool_hash[i][7:0] = 8'($urandom_range(240, 255));
    end
    for (int i = 0; i < count; i++) queued_ops.push_back(random_op());
    drain_table();
  endtask

  always @(posedge clk) begin : drive_ops
    bit       go;
    in_item_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      go = start;
      nxt = in_item;
      if (start && !busy) begin
        awaited_results.push_back(apply_to_shadow(in_item));
        ops_taken++;
        go = 1'b0;
      end
      if (!go && queued_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = queued_ops.pop_front();
        go = 1'b1;
      end
      start <= go;
      in_item <= nxt;
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      status_tally[out_item.status]++;
      if (awaited_results.size() == 0) begin
        log_mismatch("result with no operation outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (out_item.status !== want.status)
          log_mismatch($sformatf("status %0d, expected %0d", out_item.status, want.status));
        if (out_item.value_out !== want.value_out)
          log_mismatch($sformatf("value_out %h, expected %h", out_item.value_out,
                                 want.value_out));
        if (out_item.entry_count !== want.entry_count)
          log_mismatch($sformatf("entry_count %0d, expected %0d", out_item.entry_count,
                                 want.entry_count));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: collisions, wrap-around and removal without tombstones.
    sender_idle_pct = 30;
    settings_run++;
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0, 32'h0, 32'hFFFF_FFFF));
    queued_ops.push_back(make_op(FUNC_PUT, 32'hFFFF_FFFF, 32'h0, 32'h0));
    queued_ops.push_back(make_op(FUNC_GET, 32'hFFFF_FFFF, 32'h0, 32'h0));
    queued_ops.push_back(make_op(FUNC_GET, 32'h0, 32'h0, 32'h0));
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0, 32'h0, 32'h1234_5678));
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0000_00A0, 32'hFFFF_FFFF, 32'hA5A5_A5A5));
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0000_00B0, 32'hFFFF_FFFF, 32'h5A5A_5A5A));
    queued_ops.push_back(make_op(FUNC_GET, 32'h0000_00B0, 32'hFFFF_FFFF, 32'h0));
    queued_ops.push_back(make_op(FUNC_REMOVE, 32'h0, 32'h0, 32'h0));
    queued_ops.push_back(make_op(FUNC_GET, 32'hFFFF_FFFF, 32'h0, 32'h0));
    queued_ops.push_back(make_op(FUNC_GET, 32'h5, 32'h5, 32'h0));
    queued_ops.push_back(make_op(FUNC_REMOVE, 32'h5, 32'h5, 32'h0));
    queued_ops.push_back(make_op(FUNC_UNUSED, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF));

    // Capacity lowered while entries sit above it.
    set_table(9'd4, 9'd75);
    queued_ops.push_back(make_op(FUNC_GET, 32'h0000_00B0, 32'hFFFF_FFFF, 32'h0));
    queued_ops.push_back(make_op(FUNC_GET, 32'hFFFF_FFFF, 32'h1, 32'h0));
    queued_ops.push_back(make_op(FUNC_GET, 32'h0000_00A0, 32'h3, 32'h0));

    // Filling up to the load limit, then refused puts including one for a present key.
    set_table(9'd4, 9'd100);
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0000_00C0, 32'h0, 32'h1111_1111));
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0000_00D0, 32'h2, 32'h2222_2222));
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0000_00C0, 32'h0, 32'h3333_3333));

    // Out-of-range register values are clamped.
    set_table(9'h1FF, 9'h1FF);
    queued_ops.push_back(make_op(FUNC_GET, 32'h0000_00A0, 32'hFFFF_FFFF, 32'h0));
    set_table(9'd0, 9'd100);
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0000_00E0, 32'h7, 32'h4444_4444));
    queued_ops.push_back(make_op(FUNC_GET, 32'h0000_00C0, 32'h7, 32'h0));
    set_table(9'd256, 9'd0);
    queued_ops.push_back(make_op(FUNC_PUT, 32'h0000_00F0, 32'h9, 32'h5555_5555));
    drain_table();

    run_phase(9'd256, 9'd75, 250, 30);
    run_phase(9'd8, 9'd100, 200, 30);
    run_phase(9'd0, 9'd100, 80, 30);
    run_phase(9'd16, 9'd50, 200, 78);
    run_phase(9'h1FF, 9'h1FF, 250, 78);
    run_phase(9'd3, 9'd0, 60, 0);
    run_phase(9'd37, 9'd90, 300, 0);

    settle();
    repeat (END_WAIT) @(posedge clk);
    $display("Ran %0d operations with %0d results over %0d table settings, %0d mismatches.",
             ops_taken, results_seen, settings_run, mismatches);
    $display("Statuses: inserted %0d, updated %0d, found %0d, not found %0d, full %0d, removed %0d",
             status_tally[STAT_INSERTED], status_tally[STAT_UPDATED], status_tally[STAT_FOUND],
             status_tally[STAT_NOT_FOUND], status_tally[STAT_FULL], status_tally[STAT_REMOVED]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
